// File: src/dipt_pkg.sv
// Package: widths, coefficients and shared types of the displacement peak tracker.
`default_nettype none
package dipt_pkg;
  localparam int unsigned SampleBits = 32;
  localparam int unsigned FracBits   = 32;
  localparam int unsigned CoefFrac   = 38;
  localparam int unsigned SigW       = 64;
  localparam int unsigned CoefW      = 41;

  typedef logic signed [SigW-1:0]  sig_t;
  typedef logic signed [CoefW-1:0] coef_t;

  localparam sig_t SigMax = {1'b0, {(SigW-1){1'b1}}};
  localparam sig_t SigMin = {1'b1, {(SigW-1){1'b0}}};

  localparam coef_t ScaleK = 41'sd32723560350;

  // coefficient set codes
  typedef enum logic [1:0] {
    CsHpA = 2'd0,
    CsLpB = 2'd1,
    CsHpC = 2'd2,
    CsHpW = 2'd3
  } cset_e;

  // coefficient within a section: c1, c2, d1, d2
  function automatic coef_t coef_lookup(input cset_e cs, input logic [1:0] k);
    coef_t c;
    c = '0;
    case (cs)
      CsHpA: case (k)
        2'd0: c = 41'sd549755813888;
        2'd1: c = 41'sd274877906944;
        2'd2: c = 41'sd549731634253;
        default: c = 41'sd274853728683;
      endcase
      CsLpB: case (k)
        2'd0: c = 41'sd526253752844;
        2'd1: c = 41'sd252415709022;
        2'd2: c = 41'sd549228048307;
        default: c = 41'sd274351240874;
      endcase
      CsHpC: case (k)
        2'd0: c = 41'sd549755813888;
        2'd1: c = 41'sd274877906944;
        2'd2: c = 41'sd549514003793;
        default: c = 41'sd274636206800;
      endcase
      default: case (k)
        2'd0: c = 41'sd549755813888;
        2'd1: c = 41'sd274877906944;
        2'd2: c = 41'sd548512815993;
        default: c = 41'sd273638207584;
      endcase
    endcase
    return c;
  endfunction

  function automatic sig_t sat_add(input sig_t a, input sig_t b);
    logic signed [SigW:0] s;
    s = {a[SigW-1], a} + {b[SigW-1], b};
    if (s[SigW] != s[SigW-1]) return s[SigW] ? SigMin : SigMax;
    return s[SigW-1:0];
  endfunction

  function automatic sig_t sat_sub(input sig_t a, input sig_t b);
    logic signed [SigW:0] s;
    s = {a[SigW-1], a} - {b[SigW-1], b};
    if (s[SigW] != s[SigW-1]) return s[SigW] ? SigMin : SigMax;
    return s[SigW-1:0];
  endfunction
endpackage
`default_nettype wire

// File: src/dipt_if.sv
// Interfaces: input item, result item and configuration write channels.
`default_nettype none
interface dipt_in_if #(parameter int unsigned SAMPLE_BITS = 32);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          clear_extremes;
  modport source (output valid, sample, clear_extremes, input ready);
  modport sink   (input valid, sample, clear_extremes, output ready);
endinterface

interface dipt_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] filtered_value;
  logic signed [63:0] peak_high;
  logic signed [63:0] peak_low;
  modport source (output valid, filtered_value, peak_high, peak_low, input ready);
  modport sink   (input valid, filtered_value, peak_high, peak_low, output ready);
endinterface

interface dipt_cfg_if;
  logic valid;
  logic ready;
  logic strong_mode;
  modport source (output valid, strong_mode, input ready);
  modport sink   (input valid, strong_mode, output ready);
endinterface
`default_nettype wire

// File: src/displacement_iir_peak_tracker.sv
// Top level: displacement IIR peak tracker with one shared multiplier and sequencer.
//
// Channels: in_if takes one sample with a clear_extremes flag per transaction;
// out_if returns filtered_value, peak_high and peak_low for each sample;
// cfg_if writes strong_mode (reset 1); the user must write it only while
// the block is idle, as the block leaves this check to the user. The block
// works on one sample at a time under a small sequencer. Every coefficient
// product goes through one shared 64x41 multiplier that forms four 32x32
// partial products, then rounds and saturates before it raises done; each
// product passes through the start, wait and accumulate states. Strong mode
// uses 17 products (scale plus four per section), weak mode 12.
// in_if.ready is high only while the sequencer is idle and the output
// register is empty; a stalled receiver holds the result and in turn
// holds off the next sample. Reset clears all section delays, the
// integrator, and sets the peaks to their empty values.
`default_nettype none
module displacement_iir_peak_tracker #(
  parameter int unsigned SAMPLE_BITS = dipt_pkg::SampleBits,
  parameter int unsigned FRAC_BITS   = dipt_pkg::FracBits
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dipt_in_if.sink    in_if,
  dipt_out_if.source out_if,
  dipt_cfg_if.sink   cfg_if
);
  import dipt_pkg::*;

  localparam int unsigned ScaleSh = CoefFrac + SAMPLE_BITS - 1 - FRAC_BITS;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StStart = 5'b00010,
    StWait  = 5'b00100,
    StAcc   = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  state_e      st_q, st_d;
  sig_t        dly_q [16];
  sig_t        integ_q, phi_q, plo_q;
  logic        mode_q;
  sig_t        x_q, y_q;          // section input and running sum
  logic [1:0]  sec_q;             // section within the chain
  logic [1:0]  tap_q;             // product within the section
  logic        scl_q;             // scale product pending
  logic        oval_q;
  sig_t        of_q, oh_q, ol_q;
  sig_t        in_x;
  logic [3:0]  base;
  cset_e       cs;
  sig_t        ma;
  coef_t       mb;
  logic [6:0]  msh;
  logic        mdone, mstart;
  sig_t        mp;
  logic        last_sec;
  sig_t        ynew;
  sig_t        lim_hi, lim_lo;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = (st_q == StIdle) && !oval_q;
  assign base         = {sec_q, 2'b00};
  assign last_sec     = mode_q ? (sec_q == 2'd3) : (sec_q == 2'd2);

  always_comb begin
    cs = CsLpB;
    if (mode_q) begin
      case (sec_q)
        2'd0: cs = CsHpA;
        2'd1: cs = CsLpB;
        default: cs = CsHpC;
      endcase
    end else begin
      cs = (sec_q == 2'd0) ? CsLpB : CsHpW;
    end
  end

  always_comb begin
    ma  = scl_q ? x_q : dly_q[base + {2'b00, tap_q}];
    mb  = scl_q ? ScaleK : coef_lookup(cs, tap_q);
    msh = scl_q ? 7'(ScaleSh) : 7'(CoefFrac);
  end

  assign mstart = (st_q == StStart);

  dipt_mul u_mul (
    .clk_i, .rst_ni,
    .start_i(mstart), .a_i(ma), .b_i(mb), .sh_i(msh),
    .done_o(mdone), .p_o(mp)
  );

  // weak-mode input: sample shifted up, saturated
  always_comb begin
    lim_hi = SigMax >>> FRAC_BITS;
    lim_lo = ~lim_hi;
    if (SigW'(in_if.sample) > lim_hi)      in_x = SigMax;
    else if (SigW'(in_if.sample) < lim_lo) in_x = SigMin;
    else                                   in_x = SigW'(in_if.sample) <<< FRAC_BITS;
  end

  always_comb begin
    ynew = y_q;
    case (tap_q)
      2'd0: ynew = sat_sub(y_q, mp);
      2'd1: ynew = sat_add(y_q, mp);
      2'd2: ynew = sat_add(y_q, mp);
      default: ynew = sat_sub(y_q, mp);
    endcase
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle:  if (in_if.valid && in_if.ready) st_d = StStart;
      StStart: st_d = StWait;
      StWait:  if (mdone) st_d = StAcc;
      StAcc:   st_d = (!scl_q && tap_q == 2'd3 && last_sec) ? StOut : StStart;
      StOut:   st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      mode_q  <= 1'b1;
      oval_q  <= 1'b0;
      integ_q <= '0;
      phi_q   <= SigMin;
      plo_q   <= SigMax;
      for (int i = 0; i < 16; i++) dly_q[i] <= '0;
      sec_q <= '0; tap_q <= '0; scl_q <= 1'b0;
      x_q <= '0; y_q <= '0; of_q <= '0; oh_q <= '0; ol_q <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_if.valid) mode_q <= cfg_if.strong_mode;
      if (out_if.valid && out_if.ready) oval_q <= 1'b0;
      case (st_q)
        StIdle: if (in_if.valid && in_if.ready) begin
          if (in_if.clear_extremes) begin
            phi_q <= SigMin;
            plo_q <= SigMax;
          end
          sec_q <= '0; tap_q <= '0;
          scl_q <= mode_q;
          x_q   <= mode_q ? SigW'(in_if.sample) : in_x;
          y_q   <= in_x;
        end
        StAcc: begin
          if (scl_q) begin
            scl_q <= 1'b0;
            x_q   <= mp;
            y_q   <= mp;
          end else if (tap_q != 2'd3) begin
            tap_q <= tap_q + 2'd1;
            y_q   <= ynew;
          end else begin
            // close the section: shift delays, feed next section
            dly_q[base + 4'd1] <= dly_q[base];
            dly_q[base]        <= x_q;
            dly_q[base + 4'd3] <= dly_q[base + 4'd2];
            dly_q[base + 4'd2] <= ynew;
            tap_q <= '0;
            sec_q <= sec_q + 2'd1;
            if (mode_q && sec_q == 2'd1) begin
              integ_q <= sat_add(integ_q, ynew);
              x_q     <= sat_add(integ_q, ynew);
              y_q     <= sat_add(integ_q, ynew);
            end else begin
              x_q <= ynew;
              y_q <= ynew;
            end
            if (last_sec) begin
              oval_q <= 1'b1;
              of_q   <= ynew;
              if (mode_q) begin
                oh_q  <= (ynew > phi_q) ? ynew : phi_q;
                ol_q  <= (ynew < plo_q) ? ynew : plo_q;
                phi_q <= (ynew > phi_q) ? ynew : phi_q;
                plo_q <= (ynew < plo_q) ? ynew : plo_q;
              end else begin
                oh_q <= phi_q;
                ol_q <= plo_q;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_if.valid          = oval_q && (st_q == StIdle);
  assign out_if.filtered_value = of_q;
  assign out_if.peak_high      = oh_q;
  assign out_if.peak_low       = ol_q;
endmodule
`default_nettype wire

// File: src/dipt_mul.sv
// Module: shared signed multiplier, split into four 32x32 partial products over cycles.
`default_nettype none
module dipt_mul (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire dipt_pkg::sig_t      a_i,
  input  wire dipt_pkg::coef_t     b_i,
  input  wire logic [6:0]          sh_i,
  output logic                     done_o,
  output dipt_pkg::sig_t           p_o
);
  import dipt_pkg::*;

  logic        neg_q, neg_d;
  logic [63:0] ua_q, ua_d;
  logic [63:0] ub_q, ub_d;
  logic [127:0] acc_q, acc_d;
  logic [2:0]  step_q, step_d;
  logic        busy_q, busy_d;
  logic [6:0]  sh_q, sh_d;
  logic [31:0] pa, pb;
  logic [63:0] pp;
  logic [127:0] sgn, rnd, sft;
  logic        fits;
  sig_t        res;

  always_comb begin
    pa = step_q[1] ? ua_q[63:32] : ua_q[31:0];
    pb = step_q[0] ? ub_q[63:32] : ub_q[31:0];
    pp = {32'd0, pa} * {32'd0, pb};
  end

  always_comb begin
    sgn = neg_q ? (~acc_q + 128'd1) : acc_q;
    rnd = sgn + (128'd1 << (sh_q - 7'd1));
    sft = $signed(rnd) >>> sh_q;
    fits = (sft[127:63] == '0) || (sft[127:63] == '1);
    res = fits ? sft[63:0] : (sft[127] ? SigMin : SigMax);
  end

  always_comb begin
    neg_d = neg_q; ua_d = ua_q; ub_d = ub_q; acc_d = acc_q;
    step_d = step_q; busy_d = busy_q; sh_d = sh_q;
    if (start_i) begin
      neg_d  = a_i[63] ^ b_i[CoefW-1];
      ua_d   = a_i[63] ? (64'd0 - a_i) : a_i;
      ub_d   = b_i[CoefW-1] ? (64'd0 - 64'(b_i)) : 64'(b_i);
      acc_d  = '0;
      step_d = '0;
      busy_d = 1'b1;
      sh_d   = sh_i;
    end else if (busy_q) begin
      acc_d  = acc_q + ({64'd0, pp} << ((7'(step_q[1]) + 7'(step_q[0])) << 5));
      step_d = step_q + 3'd1;
      if (step_q == 3'd3) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d; ua_q <= ua_d; ub_q <= ub_d; acc_q <= acc_d; sh_q <= sh_d;
  end

  assign done_o = (step_q == 3'd4) && !busy_q;
  assign p_o    = res;
endmodule
`default_nettype wire
